// ----- sv/ppfp_pkg.sv -----
// Package for the ping/pong frame parser: status codes, layout constants and
// the time-code sign test. No dependencies.
package ppfp_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_TRUNC    = 2'd2,
    STATUS_RANGE    = 2'd3
  } status_t;

  typedef logic [7:0]  byte_t;
  typedef logic [4:0]  pos_t;
  typedef logic [15:0] seq_t;
  typedef logic [63:0] code_t;

  // Frame lengths in bytes for the two layouts.
  localparam pos_t PING_LEN = 5'd16;
  localparam pos_t PONG_LEN = 5'd25;

  // Byte positions of literals and fields.
  localparam pos_t POS_P      = 5'd0;
  localparam pos_t POS_KIND   = 5'd1;
  localparam pos_t POS_N      = 5'd2;
  localparam pos_t POS_G      = 5'd3;
  localparam pos_t POS_BAR0   = 5'd4;
  localparam pos_t POS_SEQ_HI = 5'd6;
  localparam pos_t POS_BAR1   = 5'd7;
  localparam pos_t POS_TA_HI  = 5'd15;
  localparam pos_t POS_BAR2   = 5'd16;

  // Literal characters.
  localparam byte_t CHAR_P   = 8'h50;
  localparam byte_t CHAR_I   = 8'h49;
  localparam byte_t CHAR_O   = 8'h4F;
  localparam byte_t CHAR_N   = 8'h4E;
  localparam byte_t CHAR_G   = 8'h47;
  localparam byte_t CHAR_BAR = 8'h7C;

  localparam seq_t MAX_SEQ_RESET = 16'd1000;
  localparam int   SIGN_BIT      = 63;
  localparam int   MANT_W        = 52;

  // A time code is negative when its sign bit is set and its mantissa is nonzero.
  function automatic logic is_negative(input code_t code);
    is_negative = code[SIGN_BIT] && (code[MANT_W-1:0] != '0);
  endfunction

endpackage

// ----- sv/ppfp_if.sv -----
// Handshake interfaces for the ping/pong frame parser: frame bytes, results
// and the configuration write channel. Depends on ppfp_pkg.

interface ppfp_byte_if
  import ppfp_pkg::*;
  ;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  frame_end;

  modport source (output valid, data_byte, frame_end, input ready);
  modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

interface ppfp_result_if
  import ppfp_pkg::*;
  ;
  logic    valid;
  logic    ready;
  status_t frame_status;
  logic    frame_kind;
  seq_t    sequence_number;
  code_t   time_a_code;
  code_t   time_b_code;

  modport source (output valid, frame_status, frame_kind, sequence_number,
                  time_a_code, time_b_code, input ready);
  modport sink   (input valid, frame_status, frame_kind, sequence_number,
                  time_a_code, time_b_code, output ready);
endinterface

interface ppfp_cfg_if
  import ppfp_pkg::*;
  ;
  logic valid;
  logic ready;
  seq_t max_sequence;

  modport source (output valid, max_sequence, input ready);
  modport sink   (input valid, max_sequence, output ready);
endinterface

// ----- sv/ping_pong_frame_parser.sv -----
// Top level of the ping/pong frame parser: byte-serial frame state, result
// register and the max_sequence register. Depends on ppfp_pkg and ppfp_if.
//
// Throughput: one frame byte per cycle; ready drops only while the result
// register holds a result that has not been taken.
// The result is valid in the cycle after the transaction of the last byte.
// Reset (synchronous, active high): clears the frame state and the result
// valid flag and sets max_sequence to 1000.
module ping_pong_frame_parser
  import ppfp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ppfp_byte_if.sink     frame,
  ppfp_result_if.source result,
  ppfp_cfg_if.sink      cfg
);

  // Frame state.
  pos_t  byte_position;
  logic  kind_seen;
  logic  mismatch_seen;
  seq_t  sequence_shift;
  code_t time_a_shift;
  code_t time_b_shift;
  seq_t  max_sequence;

  pos_t  byte_position_next;
  logic  kind_seen_next;
  logic  mismatch_seen_next;
  seq_t  sequence_shift_next;
  code_t time_a_shift_next;
  code_t time_b_shift_next;

  logic    res_valid;
  status_t status_next;
  logic    take;
  logic    lit_check;
  byte_t   lit_char;
  logic    fire;

  assign fire        = frame.valid && frame.ready;
  assign frame.ready = !res_valid || result.ready;
  assign cfg.ready   = 1'b1;

  // Update of the frame state for one byte.
  always_comb begin
    byte_position_next  = byte_position;
    kind_seen_next      = kind_seen;
    mismatch_seen_next  = mismatch_seen;
    sequence_shift_next = sequence_shift;
    time_a_shift_next   = time_a_shift;
    time_b_shift_next   = time_b_shift;
    lit_check           = 1'b0;
    lit_char            = CHAR_P;
    take = !mismatch_seen && (byte_position < (kind_seen ? PONG_LEN : PING_LEN));
    if (take) begin
      priority if (byte_position == POS_P) begin
        lit_check = 1'b1;
        lit_char  = CHAR_P;
      end else if (byte_position == POS_KIND) begin
        if (frame.data_byte == CHAR_I) begin
          kind_seen_next = 1'b0;
        end else if (frame.data_byte == CHAR_O) begin
          kind_seen_next = 1'b1;
        end else begin
          mismatch_seen_next = 1'b1;
        end
      end else if (byte_position == POS_N) begin
        lit_check = 1'b1;
        lit_char  = CHAR_N;
      end else if (byte_position == POS_G) begin
        lit_check = 1'b1;
        lit_char  = CHAR_G;
      end else if (byte_position == POS_BAR0 || byte_position == POS_BAR1 ||
                   byte_position == POS_BAR2) begin
        lit_check = 1'b1;
        lit_char  = CHAR_BAR;
      end else if (byte_position <= POS_SEQ_HI) begin
        sequence_shift_next = {sequence_shift[7:0], frame.data_byte};
      end else if (byte_position <= POS_TA_HI) begin
        time_a_shift_next = {time_a_shift[55:0], frame.data_byte};
      end else begin
        time_b_shift_next = {time_b_shift[55:0], frame.data_byte};
      end
      if (lit_check && frame.data_byte != lit_char) begin
        mismatch_seen_next = 1'b1;
      end
      byte_position_next = byte_position + 5'd1;
    end
  end

  // Frame status from the updated state; mismatch wins over truncation,
  // which wins over range errors.
  always_comb begin
    priority if (mismatch_seen_next) begin
      status_next = STATUS_MISMATCH;
    end else if (byte_position_next < (kind_seen_next ? PONG_LEN : PING_LEN)) begin
      status_next = STATUS_TRUNC;
    end else if (sequence_shift_next > max_sequence ||
                 is_negative(time_a_shift_next) ||
                 (kind_seen_next && is_negative(time_b_shift_next))) begin
      status_next = STATUS_RANGE;
    end else begin
      status_next = STATUS_OK;
    end
  end

  // Frame state registers; the last byte of a frame clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      kind_seen      <= 1'b0;
      mismatch_seen  <= 1'b0;
      sequence_shift <= '0;
      time_a_shift   <= '0;
      time_b_shift   <= '0;
    end else if (fire) begin
      if (frame.frame_end) begin
        byte_position  <= '0;
        kind_seen      <= 1'b0;
        mismatch_seen  <= 1'b0;
        sequence_shift <= '0;
        time_a_shift   <= '0;
        time_b_shift   <= '0;
      end else begin
        byte_position  <= byte_position_next;
        kind_seen      <= kind_seen_next;
        mismatch_seen  <= mismatch_seen_next;
        sequence_shift <= sequence_shift_next;
        time_a_shift   <= time_a_shift_next;
        time_b_shift   <= time_b_shift_next;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && frame.frame_end) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload register; the sequence number and time codes are zero on mismatch or truncation.
  always_ff @(posedge clk) begin
    if (fire && frame.frame_end) begin
      result.frame_status <= status_next;
      result.frame_kind   <= mismatch_seen_next ? 1'b0 : kind_seen_next;
      if (status_next == STATUS_MISMATCH || status_next == STATUS_TRUNC) begin
        result.sequence_number <= '0;
        result.time_a_code     <= '0;
        result.time_b_code     <= '0;
      end else begin
        result.sequence_number <= sequence_shift_next;
        result.time_a_code     <= time_a_shift_next;
        result.time_b_code     <= kind_seen_next ? time_b_shift_next : '0;
      end
    end
  end

  assign result.valid = res_valid;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_sequence <= MAX_SEQ_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_sequence <= cfg.max_sequence;
    end
  end

endmodule
